// ===== rtl/wpp_pkg.sv =====
// Shared constants and types for the world point to pixel projection block.
package wpp_pkg;

  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned CfgW    = 48;

  localparam logic [RegIdxW-1:0] RegRot0  = 3'd0;
  localparam logic [RegIdxW-1:0] RegRot1  = 3'd1;
  localparam logic [RegIdxW-1:0] RegRot2  = 3'd2;
  localparam logic [RegIdxW-1:0] RegTx    = 3'd3;
  localparam logic [RegIdxW-1:0] RegTy    = 3'd4;
  localparam logic [RegIdxW-1:0] RegTz    = 3'd5;
  localparam logic [RegIdxW-1:0] RegFocal = 3'd6;
  localparam logic [RegIdxW-1:0] RegPrinc = 3'd7;

  localparam logic [47:0] RotRow0Rst = 48'd70368744177664;
  localparam logic [47:0] RotRow1Rst = 48'd1073741824;
  localparam logic [47:0] RotRow2Rst = 48'd16384;
  localparam logic [31:0] TransXRst  = 32'hFFFF_8800;  // -120.0 in Q24.8
  localparam logic [47:0] FocalRst   = 48'd35548590786560;
  localparam logic [47:0] PrincRst   = 48'd22340709620531;

  localparam int unsigned QBits  = 24;   // quotient bits of the pixel divide
  localparam int unsigned CamW   = 37;   // camera coordinate after rounding
  localparam int unsigned DenW   = 46;   // 2 * 256 * z
  localparam int unsigned RemW   = 72;   // divider remainder
  localparam int unsigned NumW   = 66;   // 2*n + d
  localparam int unsigned PreStg = 6;
  localparam int unsigned NumStg = PreStg + QBits + 1;

  typedef struct packed {
    logic [RemW-1:0]  rem_u;
    logic [RemW-1:0]  rem_v;
    logic [DenW-1:0]  den;
    logic [QBits-1:0] q_u;
    logic [QBits-1:0] q_v;
    logic             neg_u;
    logic             neg_v;
    logic             ovf_u;
    logic             ovf_v;
    logic             behind;
    logic [31:0]      depth;
  } div_t;

endpackage

// ===== rtl/world_point_to_pixel_projection.sv =====
// Pinhole projection of world points to pixel coordinates, fully pipelined.
// Throughput: one beat per cycle unless the output stalls; a 24-stage restoring
//   divider (one quotient bit per stage, u and v lanes side by side) sets the depth of the pipe.
// A stall on the output freezes every stage at once; nothing is lost.
// Reset clears the valid bits and loads the pose and intrinsic registers.
module world_point_to_pixel_projection (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wpp_pkg::RegIdxW-1:0]   cfg_index_i,
  input  logic [wpp_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [95:0]                   s_axis_tdata,   // point_x, point_y, point_z
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [79:0]                   m_axis_tdata,   // pixel_u, pixel_v, cam_depth
  output logic                          m_axis_tuser    // behind_camera
);
  import wpp_pkg::*;

  // Configuration registers
  logic [47:0] rot_q [3];
  logic [31:0] trans_q [3];
  logic [47:0] focal_q, princ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0]   <= RotRow0Rst;
      rot_q[1]   <= RotRow1Rst;
      rot_q[2]   <= RotRow2Rst;
      trans_q[0] <= TransXRst;
      trans_q[1] <= '0;
      trans_q[2] <= '0;
      focal_q    <= FocalRst;
      princ_q    <= PrincRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegRot0:  rot_q[0]   <= cfg_data_i;
        RegRot1:  rot_q[1]   <= cfg_data_i;
        RegRot2:  rot_q[2]   <= cfg_data_i;
        RegTx:    trans_q[0] <= cfg_data_i[31:0];
        RegTy:    trans_q[1] <= cfg_data_i[31:0];
        RegTz:    trans_q[2] <= cfg_data_i[31:0];
        RegFocal: focal_q    <= cfg_data_i;
        RegPrinc: princ_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global advance: the whole pipe moves unless the output holds a beat
  // that the sink refuses.
  logic [NumStg-1:0] vld_q;
  logic              adv;

  assign adv           = !vld_q[NumStg-1] || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStg-2:0], s_axis_tvalid};
    end
  end

  // Stage 1: nine rotation products, Q2.14 times Q24.8
  logic signed [47:0] prod_q [3][3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= $signed(rot_q[r][47-16*c -: 16]) *
                          $signed(s_axis_tdata[32*c +: 32]);
        end
      end
    end
  end

  // Stage 2: sum with translation, round half up to Q.8
  logic signed [CamW-1:0] cam_q [3];
  logic signed [50:0]     acc [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 51'(prod_q[r][0]) + 51'(prod_q[r][1]) + 51'(prod_q[r][2]) +
               (51'($signed(trans_q[r])) <<< 14) + 51'sd8192;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        cam_q[r] <= acc[r][50:14];
      end
    end
  end

  // Stage 3: intrinsic products, depth test, depth saturation
  logic signed [61:0]     fu_q, cu_q, fv_q, cv_q;
  logic [DenW-1:0]        den3_q;
  logic                   behind3_q;
  logic [31:0]            depth3_q;
  logic signed [CamW-1:0] z;

  assign z = cam_q[2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fu_q      <= $signed({1'b0, focal_q[47:24]}) * cam_q[0];
      cu_q      <= $signed({1'b0, princ_q[47:24]}) * z;
      fv_q      <= $signed({1'b0, focal_q[23:0]}) * cam_q[1];
      cv_q      <= $signed({1'b0, princ_q[23:0]}) * z;
      den3_q    <= {z, 9'd0};
      behind3_q <= z[CamW-1] || (z == '0);
      if (z > CamW'(33'sh0_7FFF_FFFF)) begin
        depth3_q <= 32'h7FFF_FFFF;
      end else if (z < -CamW'(33'sh0_8000_0000)) begin
        depth3_q <= 32'h8000_0000;
      end else begin
        depth3_q <= z[31:0];
      end
    end
  end

  // Stage 4: numerators 2*n + d, with d = 256*z as half the divisor
  logic signed [NumW-1:0] num_u_q, num_v_q;
  logic [DenW-1:0]        den4_q;
  logic                   behind4_q;
  logic [31:0]            depth4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_u_q   <= ((NumW'(fu_q) + NumW'(cu_q)) <<< 1) + NumW'(den3_q >> 1);
      num_v_q   <= ((NumW'(fv_q) + NumW'(cv_q)) <<< 1) + NumW'(den3_q >> 1);
      den4_q    <= den3_q;
      behind4_q <= behind3_q;
      depth4_q  <= depth3_q;
    end
  end

  // Stage 5: magnitudes that turn the floor divide into an unsigned one
  logic [RemW-1:0] mag_u_q, mag_v_q;
  logic            neg_u5_q, neg_v5_q;
  logic [DenW-1:0] den5_q;
  logic            behind5_q;
  logic [31:0]     depth5_q;
  logic [RemW-1:0] ext_u, ext_v, den_ext;

  assign ext_u   = RemW'(num_u_q);
  assign ext_v   = RemW'(num_v_q);
  assign den_ext = RemW'(den4_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      neg_u5_q  <= num_u_q[NumW-1];
      neg_v5_q  <= num_v_q[NumW-1];
      mag_u_q   <= num_u_q[NumW-1] ? (den_ext - ext_u - RemW'(1)) : ext_u;
      mag_v_q   <= num_v_q[NumW-1] ? (den_ext - ext_v - RemW'(1)) : ext_v;
      den5_q    <= den4_q;
      behind5_q <= behind4_q;
      depth5_q  <= depth4_q;
    end
  end

  // Stage 6: overflow check against the full quotient range
  div_t            div_q [QBits+1];
  logic [RemW-1:0] den_top;

  assign den_top = RemW'(den5_q) << QBits;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q[0].rem_u  <= mag_u_q;
      div_q[0].rem_v  <= mag_v_q;
      div_q[0].den    <= den5_q;
      div_q[0].q_u    <= '0;
      div_q[0].q_v    <= '0;
      div_q[0].neg_u  <= neg_u5_q;
      div_q[0].neg_v  <= neg_v5_q;
      div_q[0].ovf_u  <= mag_u_q >= den_top;
      div_q[0].ovf_v  <= mag_v_q >= den_top;
      div_q[0].behind <= behind5_q;
      div_q[0].depth  <= depth5_q;
    end
  end

  // Restoring divider: one quotient bit per stage, MSB first
  for (genvar i = 0; i < QBits; i++) begin : g_div
    localparam int unsigned Sh = QBits - 1 - i;
    div_t            nxt;
    logic [RemW-1:0] dsh;
    logic            ge_u, ge_v;

    assign dsh  = RemW'(div_q[i].den) << Sh;
    assign ge_u = div_q[i].rem_u >= dsh;
    assign ge_v = div_q[i].rem_v >= dsh;

    always_comb begin
      nxt        = div_q[i];
      nxt.q_u[Sh] = ge_u;
      nxt.q_v[Sh] = ge_v;
      if (ge_u) nxt.rem_u = div_q[i].rem_u - dsh;
      if (ge_v) nxt.rem_v = div_q[i].rem_v - dsh;
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[i+1] <= nxt;
      end
    end
  end

  // Output stage: sign, saturation, forced zero behind the camera
  div_t        fin;
  logic [23:0] u_d, v_d, u_q, v_q;
  logic [31:0] depth_q;
  logic        behind_q;

  assign fin = div_q[QBits];

  function automatic logic [23:0] sat_px(logic [23:0] q, logic neg, logic ovf);
    logic [23:0] r;
    if (!neg) begin
      r = (ovf || q[23]) ? 24'h7F_FFFF : q;
    end else begin
      r = (ovf || (q > 24'h80_0000)) ? 24'h80_0000 : (24'd0 - q);
    end
    return r;
  endfunction

  assign u_d = fin.behind ? '0 : sat_px(fin.q_u, fin.neg_u, fin.ovf_u);
  assign v_d = fin.behind ? '0 : sat_px(fin.q_v, fin.neg_v, fin.ovf_v);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      u_q      <= u_d;
      v_q      <= v_d;
      depth_q  <= fin.depth;
      behind_q <= fin.behind;
    end
  end

  assign m_axis_tvalid = vld_q[NumStg-1];
  assign m_axis_tdata  = {depth_q, v_q, u_q};
  assign m_axis_tuser  = behind_q;

  // Pixels are zero whenever the point lies behind the camera.
  a_behind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[47:0] == '0))
    else $error("pixel not zero behind camera");

  // A point in front of the camera has a positive depth.
  a_front_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (!m_axis_tdata[79] && m_axis_tdata[79:48] != '0))
    else $error("front point with non-positive depth");

  // A stall freezes the valid chain.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("valid chain moved during stall");

endmodule
